>>> rtl/cdsk_pkg.sv
`timescale 1ns / 1ps

package cdsk_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = 7;
    localparam int DIST_W         = 32;
    localparam int POS_W          = 13;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_DIAG  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RD_WAIT,
        ST_SCAN
    } cdsk_state_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DIST_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } cdsk_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DIST_W-1:0] read_value;
        logic [IDX_W-1:0]  neighbor_index;
        logic              last;
    } cdsk_out_t;

    // Condensed upper-triangle position of the pair (a, b), a != b.
    function automatic logic [POS_W-1:0] pair_pos(
        input logic [IDX_W-1:0] a,
        input logic [IDX_W-1:0] b,
        input logic [CNT_W-1:0] n
    );
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [POS_W-1:0] prod;
        logic [POS_W-1:0] tri_num;
        lo = (a < b) ? POS_W'(a) : POS_W'(b);
        hi = (a < b) ? POS_W'(b) : POS_W'(a);
        prod = lo * POS_W'(n);
        tri_num = ((lo + POS_W'(1)) * (lo + POS_W'(2))) >> 1;
        return prod - tri_num + hi;
    endfunction

endpackage

>>> rtl/cdsk_store.sv
`timescale 1ns / 1ps

module cdsk_store
    import cdsk_pkg::*;
#(
    parameter int DEPTH  = MAX_POINTS_DEF * (MAX_POINTS_DEF - 1) / 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DIST_W-1:0] wdata,
    output logic [DIST_W-1:0] rdata
);

    logic [DIST_W-1:0] mem [DEPTH];
    logic [DIST_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cdsk_ctrl.sv
`timescale 1ns / 1ps

module cdsk_ctrl
    import cdsk_pkg::*;
#(
    parameter int DEPTH  = MAX_POINTS_DEF * (MAX_POINTS_DEF - 1) / 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cdsk_in_t          item,
    input  logic [CNT_W-1:0]  num_points,
    output logic              busy,
    output logic              strobe,
    output cdsk_out_t         result,
    output logic              mem_we,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_addr,
    output logic [DIST_W-1:0] mem_wdata,
    input  logic [DIST_W-1:0] mem_rdata
);

    cdsk_state_t       state_reg, state_next;
    cdsk_in_t          item_reg, item_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]  s1_j_reg, s1_j_next;
    logic              s1_diag_reg, s1_diag_next;
    logic              found_reg, found_next;
    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic [IDX_W-1:0]  best_j_reg, best_j_next;
    logic              has_prev_reg, has_prev_next;
    logic [DIST_W-1:0] prev_d_reg, prev_d_next;
    logic [IDX_W-1:0]  prev_j_reg, prev_j_next;
    logic              strobe_reg, strobe_next;
    cdsk_out_t         rsp_reg, rsp_next;

    logic              row_oor;
    logic              col_oor;
    logic [CNT_W-1:0]  cnt_clamped;
    logic [IDX_W-1:0]  pos_b;
    logic [POS_W-1:0]  pos;
    logic              issue;
    logic [DIST_W-1:0] cand_d;
    logic              eligible;
    logic              better;
    logic [DIST_W-1:0] fin_d;
    logic [IDX_W-1:0]  fin_j;
    logic              final_pass;

    assign row_oor     = {1'b0, item_reg.row} >= num_points;
    assign col_oor     = {1'b0, item_reg.col} >= num_points;
    assign cnt_clamped = (item_reg.count > num_points) ? num_points : item_reg.count;
    assign pos_b       = (state_reg == ST_SCAN) ? j_reg[IDX_W-1:0] : item_reg.col;
    assign pos         = pair_pos(item_reg.row, pos_b, num_points);
    assign issue       = (state_reg == ST_SCAN) && (j_reg < num_points);

    // A candidate is ranked by (distance, index); each pass looks for the
    // smallest key above the one emitted by the previous pass.
    assign cand_d   = s1_diag_reg ? '0 : mem_rdata;
    assign eligible = !has_prev_reg || (cand_d > prev_d_reg) ||
                      ((cand_d == prev_d_reg) && (s1_j_reg > prev_j_reg));
    assign better   = eligible && (!found_reg || (cand_d < best_d_reg));
    assign fin_d    = better ? cand_d : best_d_reg;
    assign fin_j    = better ? s1_j_reg : best_j_reg;
    assign final_pass = ((k_reg + CNT_W'(1)) == cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            has_prev_reg <= 1'b0;
            strobe_reg   <= 1'b0;
            rsp_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
            found_reg    <= found_next;
            has_prev_reg <= has_prev_next;
            strobe_reg   <= strobe_next;
            rsp_reg      <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        s1_j_reg    <= s1_j_next;
        s1_diag_reg <= s1_diag_next;
        best_d_reg  <= best_d_next;
        best_j_reg  <= best_j_next;
        prev_d_reg  <= prev_d_next;
        prev_j_reg  <= prev_j_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        clr_addr_next = clr_addr_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        s1_valid_next = 1'b0;
        s1_j_next     = j_reg[IDX_W-1:0];
        s1_diag_next  = (j_reg[IDX_W-1:0] == item_reg.row);
        found_next    = found_reg;
        best_d_next   = best_d_reg;
        best_j_next   = best_j_reg;
        has_prev_next = has_prev_reg;
        prev_d_next   = prev_d_reg;
        prev_j_next   = prev_j_reg;
        strobe_next   = 1'b0;
        rsp_next      = '0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = ADDR_W'(pos);
        mem_wdata     = item_reg.value;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next    = ST_IDLE;
                rsp_next.last = 1'b1;
                case (item_reg.mode)
                    MODE_READ, MODE_WRITE:
                    begin
                        strobe_next = 1'b1;
                        if (row_oor || col_oor)
                        begin
                            rsp_next.status = STATUS_RANGE;
                        end
                        else if (item_reg.row == item_reg.col)
                        begin
                            if (item_reg.mode == MODE_WRITE)
                            begin
                                rsp_next.status = STATUS_DIAG;
                            end
                        end
                        else if (item_reg.mode == MODE_WRITE)
                        begin
                            mem_we = 1'b1;
                        end
                        else
                        begin
                            mem_re      = 1'b1;
                            strobe_next = 1'b0;
                            state_next  = ST_RD_WAIT;
                        end
                    end

                    MODE_QUERY:
                    begin
                        if (row_oor)
                        begin
                            strobe_next     = 1'b1;
                            rsp_next.status = STATUS_RANGE;
                        end
                        else if (cnt_clamped != '0)
                        begin
                            rsp_next.last = 1'b0;
                            cnt_next      = cnt_clamped;
                            j_next        = '0;
                            k_next        = '0;
                            found_next    = 1'b0;
                            has_prev_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        else
                        begin
                            rsp_next.last = 1'b0;
                        end
                    end

                    default:
                    begin
                        rsp_next.last = 1'b0;
                    end
                endcase
            end

            ST_RD_WAIT:
            begin
                strobe_next         = 1'b1;
                rsp_next.read_value = mem_rdata;
                rsp_next.last       = 1'b1;
                state_next          = ST_IDLE;
            end

            ST_SCAN:
            begin
                // The diagonal entry is not stored; it ranks with distance zero.
                if (issue)
                begin
                    mem_re        = (j_reg[IDX_W-1:0] != item_reg.row);
                    s1_valid_next = 1'b1;
                    j_next        = j_reg + CNT_W'(1);
                end
                if (s1_valid_reg)
                begin
                    found_next  = found_reg || better;
                    best_d_next = fin_d;
                    best_j_next = fin_j;
                    if ({1'b0, s1_j_reg} == (num_points - CNT_W'(1)))
                    begin
                        strobe_next             = 1'b1;
                        rsp_next.neighbor_index = fin_j;
                        rsp_next.last           = final_pass;
                        has_prev_next           = 1'b1;
                        prev_d_next             = fin_d;
                        prev_j_next             = fin_j;
                        found_next              = 1'b0;
                        k_next                  = k_reg + CNT_W'(1);
                        j_next                  = '0;
                        if (final_pass)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = rsp_reg;

    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> k_reg < cnt_reg)
        else $error("query pass running beyond its count");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && rsp_reg.last |-> state_reg == ST_IDLE)
        else $error("final result while the block is still working");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_DECODE))
        else $error("store written outside clear or write");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !strobe_reg && busy)
        else $error("result or idle during clearing pass");

endmodule

>>> rtl/condensed_distance_store_knn.sv
`timescale 1ns / 1ps

// Channel   Signals                  Direction  Accepted when
// command   start, busy, item        in         start high and busy low
// result    strobe, result           out        every cycle strobe is high
// config    cfg_we, cfg_wdata        in         cfg_we high
//
// A read passes through decode and a read-wait state before busy drops, a write or
// a refused item through decode only. For a nearest query, each result is one
// pass over the row through the single port of the distance store.
// After reset the store is cleared one entry a cycle, all MAX_POINTS*(MAX_POINTS-1)/2
// entries (2016 at the default), with busy held high.
// Results are never held off; each appears on strobe for exactly one cycle.
module condensed_distance_store_knn
    import cdsk_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cdsk_in_t         item,
    output logic             strobe,
    output cdsk_out_t        result,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    localparam int DEPTH  = MAX_POINTS * (MAX_POINTS - 1) / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0]  n_reg, n_next;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [DIST_W-1:0] mem_wdata;
    logic [DIST_W-1:0] mem_rdata;

    // The register holds the effective point count: zero acts as one and
    // anything above MAX_POINTS acts as the maximum.
    always_comb
    begin
        n_next = n_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                n_next = CNT_W'(1);
            end
            else if (cfg_wdata > CNT_W'(MAX_POINTS))
            begin
                n_next = CNT_W'(MAX_POINTS);
            end
            else
            begin
                n_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_reg <= n_next;
        end
    end

    cdsk_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .num_points (n_reg),
        .busy       (busy),
        .strobe     (strobe),
        .result     (result),
        .mem_we     (mem_we),
        .mem_re     (mem_re),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata)
    );

    cdsk_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
